// ===== src/lbh_pkg.sv =====
package lbh_pkg;

  localparam int LETTER_COUNT = 32;
  localparam int COUNTER_BITS = 16;
  localparam int NCOLS        = LETTER_COUNT + 2;
  localparam int COL_W        = $clog2(NCOLS);
  localparam int CODE_W       = 16;
  localparam int ROW_W        = 5;
  localparam int KIND_W       = 2;
  localparam int WORDS_W      = 32;
  localparam int FIRST_BASE   = LETTER_COUNT * NCOLS;
  localparam int MEM_DEPTH    = FIRST_BASE + NCOLS;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int LOOKUP_N     = (LETTER_COUNT < 32) ? LETTER_COUNT : 32;

  localparam logic [COL_W-1:0]        COL_END   = COL_W'(LETTER_COUNT);
  localparam logic [COL_W-1:0]        COL_OTHER = COL_W'(LETTER_COUNT + 1);
  localparam logic [COUNTER_BITS-1:0] CNT_MAX   = {COUNTER_BITS{1'b1}};
  localparam logic [WORDS_W-1:0]      WORDS_MAX = {WORDS_W{1'b1}};

  localparam logic [CODE_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [CODE_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CODE_W-1:0] CH_SEMI  = 16'h003B;
  localparam logic [CODE_W-1:0] CH_COMMA = 16'h002C;
  localparam logic [CODE_W-1:0] CH_COLON = 16'h003A;
  localparam logic [CODE_W-1:0] CH_STAR  = 16'h002A;

  // Polish alphabet order; diacritic forms follow their base letter
  localparam logic [CODE_W-1:0] LETTER_CODES [32] = '{
    16'h0061, 16'h0105, 16'h0062, 16'h0063, 16'h0107, 16'h0064, 16'h0065, 16'h0119,
    16'h0066, 16'h0067, 16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h0142,
    16'h006D, 16'h006E, 16'h0144, 16'h006F, 16'h00F3, 16'h0070, 16'h0072, 16'h0073,
    16'h015B, 16'h0074, 16'h0075, 16'h0077, 16'h0079, 16'h007A, 16'h017A, 16'h017C
  };

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR     = 2'd0,
    KIND_RD_PAIR  = 2'd1,
    KIND_RD_FIRST = 2'd2,
    KIND_NOP      = 2'd3
  } kind_t;

  // One counter operation: increment, or read with the word total taken at issue
  typedef struct packed {
    logic               rd;
    logic               zero;
    logic [ADDR_W-1:0]  addr;
    logic [WORDS_W-1:0] words;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CODE_W-1:0] fold_lower(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] r;
    r = c;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      r = c + 16'h0020;
    end else begin
      case (c)
        16'h0104, 16'h0106, 16'h0118, 16'h0141, 16'h0143,
        16'h015A, 16'h0179, 16'h017B: r = c + 16'h0001;
        16'h00D3:                      r = 16'h00F3;
        default:                       r = c;
      endcase
    end
    return r;
  endfunction

  function automatic logic is_sep(input logic [CODE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_DOT) || (c == CH_SEMI) ||
           (c == CH_COMMA) || (c == CH_COLON);
  endfunction

  function automatic logic [COL_W-1:0] column_of(input logic [CODE_W-1:0] c);
    logic [COL_W-1:0] r;
    r = COL_OTHER;
    for (int i = 0; i < LOOKUP_N; i++) begin
      if (LETTER_CODES[i] == c) r = COL_W'(i);
    end
    if (is_sep(c) || c == CH_STAR) r = COL_END;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pair_addr(input logic [COL_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(NCOLS) + ADDR_W'(col);
  endfunction

  function automatic logic [ADDR_W-1:0] first_addr(input logic [COL_W-1:0] col);
    return ADDR_W'(FIRST_BASE) + ADDR_W'(col);
  endfunction

endpackage

// ===== src/lbh_ram.sv =====
module lbh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lbh_front.sv =====
module lbh_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [lbh_pkg::KIND_W-1:0]    kind,
  input  logic [lbh_pkg::CODE_W-1:0]    char_code,
  input  logic [lbh_pkg::ROW_W-1:0]     row_index,
  input  logic [lbh_pkg::COL_W-1:0]     col_index,
  output logic                          push,
  output lbh_pkg::op_t                  push_op,
  output logic [lbh_pkg::WORDS_W-1:0]   words_now
);
  import lbh_pkg::*;

  logic               at_ws_r, at_ws_nxt;
  logic [COL_W-1:0]   prev_r, prev_nxt;
  logic [WORDS_W-1:0] words_r, words_nxt;

  logic [CODE_W-1:0]  folded;
  logic [COL_W-1:0]   cc;
  logic               sep;
  logic               prev_letter;
  logic               need;
  op_t                op;

  assign folded      = fold_lower(char_code);
  assign cc          = column_of(folded);
  assign sep         = is_sep(folded);
  assign prev_letter = (prev_r < COL_W'(LETTER_COUNT));

  always_comb begin
    at_ws_nxt = at_ws_r;
    prev_nxt  = prev_r;
    words_nxt = words_r;
    need      = 1'b0;
    op.rd     = 1'b0;
    op.zero   = 1'b0;
    op.addr   = '0;
    op.words  = words_r;
    unique case (kind_t'(kind))
      KIND_CHAR: begin
        if (at_ws_r) begin
          need      = 1'b1;
          op.addr   = first_addr(cc);
          words_nxt = (words_r != WORDS_MAX) ? words_r + 1'b1 : words_r;
          at_ws_nxt = 1'b0;
          prev_nxt  = cc;
        end else if (sep) begin
          need      = prev_letter;
          op.addr   = pair_addr(prev_r, COL_END);
          at_ws_nxt = 1'b1;
        end else begin
          need      = prev_letter;
          op.addr   = pair_addr(prev_r, cc);
          prev_nxt  = cc;
        end
      end
      KIND_RD_PAIR: begin
        need    = 1'b1;
        op.rd   = 1'b1;
        op.zero = ({1'b0, row_index} >= (ROW_W + 1)'(LETTER_COUNT)) ||
                  (col_index >= COL_W'(NCOLS));
        op.addr = op.zero ? '0 : pair_addr(COL_W'(row_index), col_index);
      end
      KIND_RD_FIRST: begin
        need    = 1'b1;
        op.rd   = 1'b1;
        op.zero = (col_index >= COL_W'(NCOLS));
        op.addr = op.zero ? '0 : first_addr(col_index);
      end
      KIND_NOP: begin
        need = 1'b0;
      end
      default: begin
        need = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_ws_r <= 1'b1;
      prev_r  <= '0;
      words_r <= '0;
    end else if (accept) begin
      at_ws_r <= at_ws_nxt;
      prev_r  <= prev_nxt;
      words_r <= words_nxt;
    end
  end

  assign push      = accept && need;
  assign push_op   = op;
  assign words_now = words_r;

endmodule

// ===== src/lbh_queue.sv =====
module lbh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lbh_pkg::op_t        push_op,
  input  logic                pop,
  output lbh_pkg::op_t        head_op,
  output lbh_pkg::q_status_t  status
);
  import lbh_pkg::*;

  op_t               slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_op      = slots_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);

endmodule

// ===== src/lbh_back.sv =====
module lbh_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lbh_pkg::q_status_t               q_status,
  input  lbh_pkg::op_t                     head_op,
  output logic                             pop,
  output logic                             clearing,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lbh_pkg::COUNTER_BITS-1:0] out_count,
  output logic [lbh_pkg::WORDS_W-1:0]      out_words
);
  import lbh_pkg::*;

  logic                    clr_r;
  logic [ADDR_W-1:0]       clr_addr_r;
  logic                    s1_valid_r;
  op_t                     s1_op_r;
  logic                    fwd_hit_r;
  logic [COUNTER_BITS-1:0] fwd_data_r;
  logic                    out_valid_r;
  logic [COUNTER_BITS-1:0] out_count_r;
  logic [WORDS_W-1:0]      out_words_r;

  logic [COUNTER_BITS-1:0] rdata, eff, incval, wdata;
  logic                    out_free, s1_done, we_inc, we;
  logic [ADDR_W-1:0]       waddr;

  assign eff      = fwd_hit_r ? fwd_data_r : rdata;
  assign incval   = (eff == CNT_MAX) ? eff : eff + 1'b1;
  assign out_free = !out_valid_r || out_ready;
  assign s1_done  = s1_valid_r && (!s1_op_r.rd || out_free);
  assign we_inc   = s1_valid_r && !s1_op_r.rd;
  assign pop      = !q_status.empty && !clr_r && (!s1_valid_r || s1_done);

  assign we    = clr_r || we_inc;
  assign waddr = clr_r ? clr_addr_r : s1_op_r.addr;
  assign wdata = clr_r ? '0 : incval;

  lbh_ram #(
    .WIDTH(COUNTER_BITS),
    .DEPTH(MEM_DEPTH)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (pop),
    .raddr(head_op.addr),
    .rdata(rdata)
  );

  // sweep every counter to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pop) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  // bypass the write that lands on the same edge as the new read
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op_r    <= head_op;
      fwd_hit_r  <= we_inc && (s1_op_r.addr == head_op.addr);
      fwd_data_r <= incval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done && s1_op_r.rd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_op_r.rd) begin
      out_count_r <= s1_op_r.zero ? '0 : eff;
      out_words_r <= s1_op_r.words;
    end
  end

  assign clearing  = clr_r;
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_words = out_words_r;

endmodule

// ===== src/letter_bigram_histogram_unit.sv =====
// Letter bigram histogram.
// Input channel (in_*): one transaction per item. in_tuser selects the kind:
// character, read pair counter, read first-character counter, or no-op.
// Characters update counters and produce no result; each read produces one
// result transaction on out_* carrying the counter and the word total.
// Throughput: one item per cycle sustained while out_tready is high; every
// counter update is one read-modify-write on the single counter RAM port
// pair, with the write of the previous update bypassed into the next read.
// Path: a read item is written into the queue, then read from the counter
// RAM, then captured in the output register that drives out_tvalid.
// Reset: rst_n clears the control state; afterwards the counter RAM is swept
// to zero address by address, during which in_tready stays low.
// Stall: if out_tready is low the result holds, the back end stops at the
// next read and the 4-entry queue fills; in_tready then drops.
module letter_bigram_histogram_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[15:0], row_index[20:16], col_index[26:21]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // count_value[15:0], words_seen[47:16]
);
  import lbh_pkg::*;

  logic               in_accept;
  logic               push, pop, clearing;
  op_t                push_op, head_op;
  q_status_t          q_status;
  logic [WORDS_W-1:0] words_now;
  logic [COUNTER_BITS-1:0] out_count;
  logic [WORDS_W-1:0] out_words;

  assign in_tready = !q_status.full && !clearing;
  assign in_accept = in_tvalid && in_tready;

  lbh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .kind     (in_tuser),
    .char_code(in_tdata[15:0]),
    .row_index(in_tdata[20:16]),
    .col_index(in_tdata[26:21]),
    .push     (push),
    .push_op  (push_op),
    .words_now(words_now)
  );

  lbh_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head_op(head_op),
    .status (q_status)
  );

  lbh_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .head_op  (head_op),
    .pop      (pop),
    .clearing (clearing),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_count(out_count),
    .out_words(out_words)
  );

  assign out_tdata = {out_words, out_count};

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !in_accept)
    else $error("input accepted during counter sweep");

  a_no_result_while_clearing: assert property (
    @(posedge clk) disable iff (!rst_n) clearing |-> !out_tvalid)
    else $error("result presented during counter sweep");

  a_words_monotonic: assert property (
    @(posedge clk) disable iff (!rst_n) 1'b1 |=> words_now >= $past(words_now))
    else $error("word total decreased");

  a_pop_needs_entry: assert property (
    @(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty && !clearing)
    else $error("queue popped while empty or sweeping");

endmodule

// ===== tb/lbh_tally_check.sv =====
module lbh_tally_check
  import lbh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[15:0], row_index[20:16], col_index[26:21]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // count_value[15:0], words_seen[47:16]
  output int          mismatch_count,
  output int          pending_reads
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORDS_W-1:0]      words;
    logic [COUNTER_BITS-1:0] count;
  } readback_t;

  logic [COUNTER_BITS-1:0] pair_tally [LETTER_COUNT][NCOLS];
  logic [COUNTER_BITS-1:0] first_tally [NCOLS];
  logic [WORDS_W-1:0]      word_tally;
  logic                    at_start;
  logic [COL_W-1:0]        prev_col;
  readback_t               expected_readbacks [$];

  function automatic logic [CODE_W-1:0] to_lower(input logic [CODE_W-1:0] c);
    if (c >= 16'h0041 && c <= 16'h005A) return c + 16'h0020;
    if (c == 16'h00D3) return 16'h00F3;
    // Polish capitals sit one code point below their small form
    if (c == 16'h0104 || c == 16'h0106 || c == 16'h0118 || c == 16'h0141 ||
        c == 16'h0143 || c == 16'h015A || c == 16'h0179 || c == 16'h017B) return c + 16'h0001;
    return c;
  endfunction

  function automatic logic breaks_word(input logic [CODE_W-1:0] c);
    return c == CH_SPACE || c == CH_DOT || c == CH_SEMI || c == CH_COMMA || c == CH_COLON;
  endfunction

  function automatic logic [COL_W-1:0] letter_column(input logic [CODE_W-1:0] c);
    if (breaks_word(c) || c == CH_STAR) return COL_END;
    for (int i = 0; i < LETTER_COUNT; i++) begin
      if (LETTER_CODES[i] == c) return COL_W'(i);
    end
    return COL_OTHER;
  endfunction

  task automatic bump_pair(input logic [COL_W-1:0] row, input logic [COL_W-1:0] col);
    // rows past the letters (end mark, other) are not tallied
    if (row < LETTER_COUNT && pair_tally[row][col] != CNT_MAX) begin
      pair_tally[row][col] = pair_tally[row][col] + 1'b1;
    end
  endtask

  task automatic count_char(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] lc;
    logic [COL_W-1:0]  col;
    lc  = to_lower(code);
    col = letter_column(lc);
    if (at_start) begin
      if (first_tally[col] != CNT_MAX) first_tally[col] = first_tally[col] + 1'b1;
      if (word_tally != WORDS_MAX) word_tally = word_tally + 1'b1;
      at_start = 1'b0;
      prev_col = col;
    end else if (breaks_word(lc)) begin
      bump_pair(prev_col, COL_END);
      at_start = 1'b1;
    end else begin
      bump_pair(prev_col, col);
      prev_col = col;
    end
  endtask

  always @(posedge clk) begin
    kind_t            kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    readback_t        want;
    readback_t        got;
    if (!rst_n) begin
      for (int r = 0; r < LETTER_COUNT; r++) begin
        for (int c = 0; c < NCOLS; c++) pair_tally[r][c] = '0;
      end
      for (int c = 0; c < NCOLS; c++) first_tally[c] = '0;
      word_tally = '0;
      at_start   = 1'b1;
      prev_col   = '0;
      expected_readbacks.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = readback_t'(out_tdata);
        if (expected_readbacks.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual count %0d words %0d",
                   $time, got.count, got.words);
        end else begin
          want = expected_readbacks.pop_front();
          if (got.count != want.count) begin
            mismatch_count++;
            $display("%0t: count_value expected %0d actual %0d", $time, want.count, got.count);
          end
          if (got.words != want.words) begin
            mismatch_count++;
            $display("%0t: words_seen expected %0d actual %0d", $time, want.words, got.words);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        kind = kind_t'(in_tuser);
        row  = in_tdata[20:16];
        col  = in_tdata[26:21];
        want.words = word_tally;
        want.count = '0;
        case (kind)
          KIND_CHAR: begin
            count_char(in_tdata[15:0]);
          end
          KIND_RD_PAIR: begin
            if (row < LETTER_COUNT && col < NCOLS) want.count = pair_tally[row][col];
            expected_readbacks.push_back(want);
          end
          KIND_RD_FIRST: begin
            if (col < NCOLS) want.count = first_tally[col];
            expected_readbacks.push_back(want);
          end
          default: begin
          end
        endcase
      end
    end
    pending_reads = expected_readbacks.size();
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;

  import lbh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CODE_W-1:0] WORD_BREAKS [5] = '{CH_SPACE, CH_DOT, CH_SEMI, CH_COMMA, CH_COLON};
  localparam int RANDOM_ITEMS = 850;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = KIND_NOP;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  int mismatches;
  int pending_reads;
  int idle_pct  = 20;
  int stall_pct = 30;

  letter_bigram_histogram_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lbh_tally_check u_tally (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatches),
    .pending_reads  (pending_reads)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int gap_length();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
  endfunction

  function automatic logic [COL_W-1:0] pick_col();
    int r;
    r = $urandom_range(9);
    if (r < 6) return COL_W'($urandom_range(5));
    if (r < 8) return COL_END;
    if (r == 8) return COL_W'($urandom_range(NCOLS - 1));
    return COL_W'($urandom_range(63));
  endfunction

  function automatic logic [CODE_W-1:0] capital_of(input logic [CODE_W-1:0] c);
    if (c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
    if (c == 16'h00F3) return 16'h00D3;
    return c - 16'h0001;
  endfunction

  task automatic push_item(input kind_t k, input logic [CODE_W-1:0] code,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? gap_length() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {5'b0, col, row, code};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_char(input logic [CODE_W-1:0] code);
    push_item(KIND_CHAR, code, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_pair(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    push_item(KIND_RD_PAIR, CODE_W'($urandom), row, col);
  endtask

  task automatic read_first(input logic [COL_W-1:0] col);
    push_item(KIND_RD_FIRST, CODE_W'($urandom), ROW_W'($urandom), col);
  endtask

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        hold = gap_length() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int sent;
    int next_shift;
    int roll;
    int len;
    int idx;
    logic [CODE_W-1:0] code;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: fresh reads, folding, separators, asterisk, other, out-of-range reads
    read_pair(5'd0, 6'd0);
    read_first(COL_OTHER);
    send_char(CH_SPACE);          // separator opening a word
    send_char(16'h0041);
    send_char(16'h0104);
    send_char(CH_STAR);           // end column without a word break
    send_char(16'h005A);          // row is the end mark: not tallied
    send_char(16'hFFFF);
    send_char(16'h0000);          // row is other: not tallied
    send_char(CH_DOT);
    send_char(16'h00D3);
    send_char(16'h017B);
    send_char(CH_COMMA);
    send_char(CH_SEMI);
    send_char(CH_COLON);
    send_char(16'h017C);
    push_item(KIND_NOP, 16'hFFFF, 5'd31, 6'd63);
    read_pair(5'd31, 6'd63);
    read_pair(5'd0, 6'd1);
    read_pair(5'd1, COL_END);
    read_first(COL_END);
    read_first(6'd63);
    read_pair(5'd20, 6'd31);
    read_pair(5'd31, COL_END);
    read_pair(5'd29, COL_OTHER);

    sent = 0;
    next_shift = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_shift) begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 60;
        endcase
        case ($urandom_range(2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 60;
        endcase
        next_shift = sent + 120;
      end
      roll = $urandom_range(99);
      if (roll < 55) begin
        // well-formed word, biased toward a few letters so pairs repeat
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
          idx  = ($urandom_range(9) < 7) ? $urandom_range(5) : $urandom_range(31);
          code = LETTER_CODES[idx];
          if ($urandom_range(3) == 0) code = capital_of(code);
          send_char(code);
        end
        send_char(WORD_BREAKS[$urandom_range(4)]);
        sent += len + 1;
      end else if (roll < 78) begin
        if ($urandom_range(3) == 0) begin
          read_first(pick_col());
        end else begin
          read_pair(($urandom_range(3) != 0) ? ROW_W'($urandom_range(5)) : ROW_W'($urandom),
                    pick_col());
        end
        sent++;
      end else if (roll < 86) begin
        code = ($urandom_range(1) == 0) ? CODE_W'($urandom) :
                                          CODE_W'($urandom_range(16'h017F, 16'h00C0));
        send_char(code);
        sent++;
      end else if (roll < 91) begin
        send_char(CH_STAR);
        sent++;
      end else if (roll < 96) begin
        // broken text: a run of separators
        len = $urandom_range(4, 1);
        repeat (len) send_char(WORD_BREAKS[$urandom_range(4)]);
        sent += len;
      end else begin
        push_item(KIND_NOP, CODE_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        sent++;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_reads != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lbh_pkg.sv
src/lbh_ram.sv
src/lbh_front.sv
src/lbh_queue.sv
src/lbh_back.sv
src/letter_bigram_histogram_unit.sv
tb/lbh_tally_check.sv
tb/testbench.sv
